[rtl/rtlt_pkg.sv]
package rtlt_pkg;

    localparam logic [31:0] NEAR_TICKS = 32'd90000;
    localparam logic [31:0] AGE_TICKS = 32'd450000;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
    localparam logic signed [63:0] MIN_NET_NS = 64'sd1000000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [16:0] BEST_INIT = 17'd90001;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_LOOKUP   = 2'd1,
        OP_CLEANUP  = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [31:0] rtp_ts;
        logic [62:0] capture_time_ns;
        logic [62:0] encode_time_ns;
        logic [62:0] rx_time_ns;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [63:0] enc_delay_ns;
        logic signed [63:0] net_delay_ns;
        logic signed [63:0] total_latency_ns;
        logic [8:0]         entry_count;
    } t_out;

    typedef struct packed {
        logic [31:0] key;
        logic [62:0] cap;
        logic [62:0] enc;
    } t_rec;

    typedef struct packed {
        logic [31:0] mag;
        logic        far;
    } t_cand;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_AR1,
        ST_AR2,
        ST_AR3,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic fin;
        logic ar1;
        logic ar2;
        logic ar3;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic out_free;
        logic is_look;
    } t_sts;

    function automatic t_cand cand(input logic [31:0] key, input logic [31:0] target);
        logic [31:0] d;
        t_cand c;
        d = key - target;
        c.mag = d[31] ? (32'd0 - d) : d;
        c.far = !d[31] && (d > NEAR_TICKS);
        return c;
    endfunction

    function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
        if (v[64] != v[63]) begin
            return v[64] ? S64_MIN : S64_MAX;
        end
        return v[63:0];
    endfunction

endpackage

[rtl/rtlt_ctrl.sv]
module rtlt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rtlt_pkg::t_sts i_sts,
    output rtlt_pkg::t_cmd o_cmd
);

    rtlt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtlt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtlt_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rtlt_pkg::ST_SCAN;
            end
            rtlt_pkg::ST_SCAN: begin
                if (i_sts.scan_end) n_state = rtlt_pkg::ST_FIN;
            end
            rtlt_pkg::ST_FIN: begin
                n_state = i_sts.is_look ? rtlt_pkg::ST_AR1 : rtlt_pkg::ST_OUT;
            end
            rtlt_pkg::ST_AR1: n_state = rtlt_pkg::ST_AR2;
            rtlt_pkg::ST_AR2: n_state = rtlt_pkg::ST_AR3;
            rtlt_pkg::ST_AR3: n_state = rtlt_pkg::ST_OUT;
            rtlt_pkg::ST_OUT: begin
                if (i_sts.out_free) n_state = rtlt_pkg::ST_IDLE;
            end
            default: n_state = rtlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rtlt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rtlt_pkg::ST_SCAN: o_cmd.scan = 1'b1;
            rtlt_pkg::ST_FIN:  o_cmd.fin = 1'b1;
            rtlt_pkg::ST_AR1:  o_cmd.ar1 = 1'b1;
            rtlt_pkg::ST_AR2:  o_cmd.ar2 = 1'b1;
            rtlt_pkg::ST_AR3:  o_cmd.ar3 = 1'b1;
            rtlt_pkg::ST_OUT:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/rtlt_dp.sv]
module rtlt_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtlt_pkg::t_in      i_in,
    input  logic               i_cfg_we,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output rtlt_pkg::t_out     o_out,
    input  rtlt_pkg::t_cmd     i_cmd,
    output rtlt_pkg::t_sts     o_sts
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] EVICT_C = CW'(TABLE_DEPTH / 4);

    rtlt_pkg::t_rec r_mem [TABLE_DEPTH];
    rtlt_pkg::t_rec r_q;
    rtlt_pkg::t_in  r_in;
    rtlt_pkg::t_rec r_carry, n_carry;
    rtlt_pkg::t_rec r_pred, n_pred;
    rtlt_pkg::t_out r_out;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_w, n_w;
    logic          r_dv;
    logic          r_done, n_done;
    logic          r_cv, n_cv;
    logic          r_reached, n_reached;
    logic          r_stop, n_stop;
    logic          r_pv, n_pv;
    logic          r_have, n_have;
    logic [16:0]   r_best, n_best;
    logic [62:0]   r_fcap, n_fcap;
    logic [62:0]   r_fenc, n_fenc;
    logic signed [63:0] r_off;
    logic signed [63:0] r_adj, r_elat, r_nlat, r_tlat;
    logic          r_out_vld;

    logic           rd_en;
    logic           we;
    rtlt_pkg::t_rec wdata;
    rtlt_pkg::t_rec new_rec;
    rtlt_pkg::t_cand c_a, c_b;
    logic [31:0]    age;
    logic signed [63:0] net;
    logic           stp;

    assign new_rec.key = r_in.rtp_ts;
    assign new_rec.cap = r_in.capture_time_ns;
    assign new_rec.enc = r_in.encode_time_ns;
    assign rd_en = i_cmd.scan && (r_rd < r_count);
    assign c_a = rtlt_pkg::cand(r_pred.key, r_in.rtp_ts);
    assign c_b = rtlt_pkg::cand(r_q.key, r_in.rtp_ts);
    assign age = r_in.rtp_ts - r_q.key;

    assign o_sts.scan_end = !(r_rd < r_count) && !r_dv;
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_sts.is_look = (r_in.operation == rtlt_pkg::OP_LOOKUP);
    assign o_out_valid = r_out_vld;
    assign o_out = r_out;

    always_comb begin
        we = 1'b0;
        wdata = r_q;
        n_w = r_w;
        n_count = r_count;
        n_carry = r_carry;
        n_cv = r_cv;
        n_done = r_done;
        n_pred = r_pred;
        n_pv = r_pv;
        n_reached = r_reached;
        n_stop = r_stop;
        n_have = r_have;
        n_best = r_best;
        n_fcap = r_fcap;
        n_fenc = r_fenc;
        stp = r_stop;
        if (r_dv) begin
            unique case (r_in.operation)
                rtlt_pkg::OP_REGISTER: begin
                    we = 1'b1;
                    if (r_cv) begin
                        wdata = r_carry;
                        n_carry = r_q;
                    end else if (!r_done && r_in.rtp_ts <= r_q.key) begin
                        wdata = new_rec;
                        n_done = 1'b1;
                        if (r_in.rtp_ts != r_q.key) begin
                            n_cv = 1'b1;
                            n_carry = r_q;
                        end
                    end
                end
                rtlt_pkg::OP_CLEANUP: begin
                    we = !(age < rtlt_pkg::HALF_RANGE && age > rtlt_pkg::AGE_TICKS);
                end
                rtlt_pkg::OP_LOOKUP: begin
                    if (!r_reached) begin
                        if (r_q.key < r_in.rtp_ts) begin
                            n_pv = 1'b1;
                            n_pred = r_q;
                        end else begin
                            n_reached = 1'b1;
                            if (r_q.key == r_in.rtp_ts) begin
                                n_have = 1'b1;
                                n_best = '0;
                                n_fcap = r_q.cap;
                                n_fenc = r_q.enc;
                                stp = 1'b1;
                            end else begin
                                if (r_pv) begin
                                    if (c_a.mag < {15'd0, n_best}) begin
                                        n_best = c_a.mag[16:0];
                                        n_have = 1'b1;
                                        n_fcap = r_pred.cap;
                                        n_fenc = r_pred.enc;
                                    end
                                    stp = c_a.far;
                                end
                                if (!stp) begin
                                    if (c_b.mag < {15'd0, n_best}) begin
                                        n_best = c_b.mag[16:0];
                                        n_have = 1'b1;
                                        n_fcap = r_q.cap;
                                        n_fenc = r_q.enc;
                                    end
                                    stp = c_b.far;
                                end
                            end
                        end
                    end else if (!r_stop) begin
                        if (c_b.mag < {15'd0, n_best}) begin
                            n_best = c_b.mag[16:0];
                            n_have = 1'b1;
                            n_fcap = r_q.cap;
                            n_fenc = r_q.enc;
                        end
                        stp = c_b.far;
                    end
                    n_stop = stp;
                end
                default: we = 1'b0;
            endcase
            if (we) n_w = r_w + 1'b1;
        end
        if (i_cmd.fin) begin
            unique case (r_in.operation)
                rtlt_pkg::OP_REGISTER: begin
                    we = !r_done || r_cv;
                    wdata = r_done ? r_carry : new_rec;
                    n_count = we ? (r_w + 1'b1) : r_w;
                end
                rtlt_pkg::OP_CLEANUP: n_count = r_w;
                rtlt_pkg::OP_CLEAR: n_count = '0;
                rtlt_pkg::OP_LOOKUP: begin
                    if (!r_reached && r_pv && c_a.mag < {15'd0, r_best}) begin
                        n_best = c_a.mag[16:0];
                        n_have = 1'b1;
                        n_fcap = r_pred.cap;
                        n_fenc = r_pred.enc;
                    end
                end
                default: n_count = r_count;
            endcase
        end
    end

    always_comb begin
        net = rtlt_pkg::sat65({r_adj[63], r_adj} - {2'b00, r_fenc});
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_q <= r_mem[r_rd[AW-1:0]];
        if (we) r_mem[r_w[AW-1:0]] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dv <= 1'b0;
            r_out_vld <= 1'b0;
            r_off <= '0;
            r_have <= 1'b0;
        end else begin
            if (i_cfg_we) r_off <= i_cfg_data;
            r_dv <= rd_en;
            r_count <= n_count;
            r_have <= i_cmd.load ? 1'b0 : n_have;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        r_pred <= n_pred;
        r_fcap <= n_fcap;
        r_fenc <= n_fenc;
        if (i_cmd.load) begin
            r_in <= i_in;
            r_w <= '0;
            r_cv <= 1'b0;
            r_done <= 1'b0;
            r_pv <= 1'b0;
            r_reached <= 1'b0;
            r_stop <= 1'b0;
            r_best <= rtlt_pkg::BEST_INIT;
            if (i_in.operation == rtlt_pkg::OP_CLEAR) begin
                r_rd <= r_count;
            end else if (i_in.operation == rtlt_pkg::OP_REGISTER && r_count == DEPTH_C) begin
                r_rd <= EVICT_C;
            end else begin
                r_rd <= '0;
            end
        end else begin
            r_w <= n_w;
            r_cv <= n_cv;
            r_done <= n_done;
            r_pv <= n_pv;
            r_reached <= n_reached;
            r_stop <= n_stop;
            r_best <= n_best;
            if (rd_en) r_rd <= r_rd + 1'b1;
        end
        if (i_cmd.ar1) begin
            r_adj <= rtlt_pkg::sat65({2'b00, r_in.rx_time_ns} - {r_off[63], r_off});
            r_elat <= $signed({1'b0, r_fenc}) - $signed({1'b0, r_fcap});
        end
        if (i_cmd.ar2) begin
            r_nlat <= net[63] ? rtlt_pkg::MIN_NET_NS : net;
        end
        if (i_cmd.ar3) begin
            r_tlat <= rtlt_pkg::sat65({r_elat[63], r_elat} + {r_nlat[63], r_nlat});
        end
        if (i_cmd.out_load) begin
            r_out.hit <= o_sts.is_look && r_have;
            r_out.enc_delay_ns <= (o_sts.is_look && r_have) ? r_elat : '0;
            r_out.net_delay_ns <= (o_sts.is_look && r_have) ? r_nlat : '0;
            r_out.total_latency_ns <= (o_sts.is_look && r_have) ? r_tlat : '0;
            r_out.entry_count <= 9'(r_count);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds table depth");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && i_cmd.scan) |-> (r_w < r_rd))
        else $error("compaction write overtook the read stream");

    a_hit_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_best <= rtlt_pkg::NEAR_TICKS[16:0]))
        else $error("match recorded outside the near window");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

[rtl/rtp_timestamp_latency_table_core.sv]
// Keeps a key-ordered table of frame records and answers latency lookups against it.
// The input channel (i_in_valid, o_in_ready, i_in) takes one request with an operation:
// register a frame, look up a key, clean up old entries, or clear the table.
// Every request returns exactly one result on the output channel (o_out_valid,
// i_out_ready, o_out), carrying the hit flag, the three latencies and the entry count.
// The configuration channel writes the signed clock offset; it is always ready.
// A request makes one pass over the table memory, reading one entry per cycle through
// its registered read port. A register on a full table skips the evicted quarter,
// and a clear reads nothing. A lookup then runs the saturating latency arithmetic
// in states ST_AR1, ST_AR2 and ST_AR3.
// The block works on one request at a time and is ready again once the result is
// handed to the output register, so a new request can be accepted while that result
// waits. If the receiver stalls and the output register is still full, the next
// finished result waits inside the block until the register frees up.
// Reset empties the table, clears the offset to zero and drops any pending result;
// the table memory itself is not cleared.
module rtp_timestamp_latency_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rtlt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rtlt_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [63:0]    i_cfg_data
);

    rtlt_pkg::t_cmd cmd;
    rtlt_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rtlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rtlt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

[bench/tb_rtp_timestamp_latency_table_core.sv]
module tb_rtp_timestamp_latency_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    rtlt_pkg::t_in i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    rtlt_pkg::t_out o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [63:0] i_cfg_data = '0;

    rtp_timestamp_latency_table_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [31:0] tbl_key[DEPTH];
    logic [62:0] tbl_cap[DEPTH];
    logic [62:0] tbl_enc[DEPTH];
    int tbl_count;
    logic signed [63:0] skew_ns;
    rtlt_pkg::t_out pending_results[$];
    int errors;
    int idle_cycles;
    bit hold_off;
    int burst_left;
    logic [31:0] key_base;

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? rtlt_pkg::S64_MIN : rtlt_pkg::S64_MAX;
        return s[63:0];
    endfunction

    function automatic int key_pos(logic [31:0] key);
        int i;
        i = 0;
        while (i < tbl_count && tbl_key[i] < key) i++;
        return i;
    endfunction

    function automatic void drop_slot(int p);
        for (int j = p; j < tbl_count - 1; j++) begin
            tbl_key[j] = tbl_key[j + 1];
            tbl_cap[j] = tbl_cap[j + 1];
            tbl_enc[j] = tbl_enc[j + 1];
        end
        tbl_count--;
    endfunction

    function automatic rtlt_pkg::t_out predict_latency(rtlt_pkg::t_in req);
        rtlt_pkg::t_out r;
        int p, found;
        logic [32:0] best, mag;
        logic [31:0] d, age;
        logic signed [63:0] c, e, adj;
        r = '0;
        case (req.operation)
            rtlt_pkg::OP_REGISTER: begin
                if (tbl_count >= DEPTH) begin
                    for (int k = 0; k < DEPTH / 4; k++) drop_slot(0);
                end
                p = key_pos(req.rtp_ts);
                if (!(p < tbl_count && tbl_key[p] == req.rtp_ts)) begin
                    for (int j = tbl_count; j > p; j--) begin
                        tbl_key[j] = tbl_key[j - 1];
                        tbl_cap[j] = tbl_cap[j - 1];
                        tbl_enc[j] = tbl_enc[j - 1];
                    end
                    tbl_count++;
                end
                tbl_key[p] = req.rtp_ts;
                tbl_cap[p] = req.capture_time_ns;
                tbl_enc[p] = req.encode_time_ns;
            end
            rtlt_pkg::OP_LOOKUP: begin
                p = key_pos(req.rtp_ts);
                found = -1;
                if (p < tbl_count && tbl_key[p] == req.rtp_ts) begin
                    found = p;
                end else begin
                    best = 33'd90001;
                    for (int i = (p > 0 ? p - 1 : 0); i < tbl_count; i++) begin
                        d = tbl_key[i] - req.rtp_ts;
                        mag = d[31] ? 33'h1_0000_0000 - {1'b0, d} : {1'b0, d};
                        if (mag < best) begin
                            best = mag;
                            found = i;
                        end
                        if (!d[31] && d > rtlt_pkg::NEAR_TICKS) break;
                    end
                end
                if (found >= 0) begin
                    c = {1'b0, tbl_cap[found]};
                    e = {1'b0, tbl_enc[found]};
                    adj = sat_sum({1'b0, req.rx_time_ns}, -skew_ns);
                    if (skew_ns == rtlt_pkg::S64_MIN) adj = rtlt_pkg::S64_MAX;
                    r.hit = 1'b1;
                    r.enc_delay_ns = e - c;
                    r.net_delay_ns = sat_sum(adj, -e);
                    if (r.net_delay_ns < 0) r.net_delay_ns = rtlt_pkg::MIN_NET_NS;
                    r.total_latency_ns = sat_sum(r.enc_delay_ns, r.net_delay_ns);
                end
            end
            rtlt_pkg::OP_CLEANUP: begin
                p = 0;
                while (p < tbl_count) begin
                    age = req.rtp_ts - tbl_key[p];
                    if (age < rtlt_pkg::HALF_RANGE && age > rtlt_pkg::AGE_TICKS) drop_slot(p);
                    else p++;
                end
            end
            default: tbl_count = 0;
        endcase
        r.entry_count = tbl_count[8:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0) || burst_left[3];
        end
    end

    always @(posedge i_clk) begin
        rtlt_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", o_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.hit !== want.hit) begin
                    $error("hit exp %0d got %0d", want.hit, o_out.hit);
                    errors++;
                end
                if (o_out.enc_delay_ns !== want.enc_delay_ns) begin
                    $error("enc_delay_ns exp %0d got %0d",
                           want.enc_delay_ns, o_out.enc_delay_ns);
                    errors++;
                end
                if (o_out.net_delay_ns !== want.net_delay_ns) begin
                    $error("net_delay_ns exp %0d got %0d",
                           want.net_delay_ns, o_out.net_delay_ns);
                    errors++;
                end
                if (o_out.total_latency_ns !== want.total_latency_ns) begin
                    $error("total_latency_ns exp %0d got %0d",
                           want.total_latency_ns, o_out.total_latency_ns);
                    errors++;
                end
                if (o_out.entry_count !== want.entry_count) begin
                    $error("entry_count exp %0d got %0d", want.entry_count, o_out.entry_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_off) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[rtp_timestamp_latency_table_core] ERROR");
            $finish;
        end
    end

    task automatic send_request(rtlt_pkg::t_op op, logic [31:0] ts, logic [62:0] cap,
                                logic [62:0] enc, logic [62:0] rcv);
        rtlt_pkg::t_in req;
        int gap;
        req.operation = op;
        req.rtp_ts = ts;
        req.capture_time_ns = cap;
        req.encode_time_ns = enc;
        req.rx_time_ns = rcv;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in <= req;
        i_in_valid <= 1'b1;
        pending_results.push_back(predict_latency(req));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [63:0] value);
        wait_drained();
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        skew_ns = value;
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic logic [62:0] rand_time();
        case ($urandom_range(0, 3))
            0: return rand63();
            1: return 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 1000));
            2: return 63'($urandom_range(0, 1000));
            default: return 63'd1_000_000_000 + 63'($urandom_range(0, 50_000_000));
        endcase
    endfunction

    task automatic test_directed();
        send_request(rtlt_pkg::OP_LOOKUP, 32'd5, '0, '0, '0);
        send_request(rtlt_pkg::OP_REGISTER, 32'd0, '0, '1, '0);
        send_request(rtlt_pkg::OP_REGISTER, 32'hFFFF_FFFF, '1, '0, '0);
        send_request(rtlt_pkg::OP_REGISTER, 32'd100000, 63'd10, 63'd20, '0);
        send_request(rtlt_pkg::OP_LOOKUP, 32'd0, '0, '0, '1);
        send_request(rtlt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
        send_request(rtlt_pkg::OP_LOOKUP, 32'd90000, '0, '0, 63'd5);
        send_request(rtlt_pkg::OP_LOOKUP, 32'd190001, '0, '0, 63'd5);
        send_request(rtlt_pkg::OP_LOOKUP, 32'd10000, '0, '0, 63'd1000);
        send_request(rtlt_pkg::OP_LOOKUP, 32'h8000_0000, '0, '0, 63'd1000);
        send_request(rtlt_pkg::OP_REGISTER, 32'd100000, 63'd7, 63'd9, '0);
        send_request(rtlt_pkg::OP_LOOKUP, 32'd100001, '0, '0, '1);
        send_request(rtlt_pkg::OP_CLEANUP, 32'd550001, '0, '0, '0);
        send_request(rtlt_pkg::OP_CLEANUP, 32'h8000_0000, '0, '0, '0);
        send_request(rtlt_pkg::OP_CLEAR, '1, '1, '1, '1);
        send_request(rtlt_pkg::OP_LOOKUP, 32'd0, '0, '0, '0);
    endtask

    task automatic test_offsets();
        logic [63:0] offs[4] = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                 64'hFFFF_FFFF_FFFF_FFFF, 64'd500};
        foreach (offs[k]) begin
            write_offset(offs[k]);
            send_request(rtlt_pkg::OP_REGISTER, 32'd42, rand_time(), rand_time(), '0);
            send_request(rtlt_pkg::OP_LOOKUP, 32'd42, '0, '0, '0);
            send_request(rtlt_pkg::OP_LOOKUP, 32'd42, '0, '0, '1);
            send_request(rtlt_pkg::OP_LOOKUP, 32'd1000, '0, '0, rand_time());
        end
        write_offset(64'd0);
    endtask

    task automatic test_fill_and_evict();
        for (int i = 0; i < DEPTH + 10; i++) begin
            send_request(rtlt_pkg::OP_REGISTER, key_base + i * 3000, rand_time(), rand_time(),
                         '0);
        end
        send_request(rtlt_pkg::OP_REGISTER, key_base + 3000 * 200, rand_time(), rand_time(), '0);
        for (int i = 0; i < 80; i++) begin
            send_request(rtlt_pkg::OP_REGISTER, key_base + 3000 * 120, rand_time(), rand_time(),
                         '0);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (DEPTH * 8) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++) begin
                    send_request(rtlt_pkg::OP_LOOKUP, key_base + $urandom_range(0, 500000),
                                 '0, '0, rand_time());
                end
                wait_drained();
            end
        join
    endtask

    task automatic test_random(int count);
        logic [31:0] ts;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) key_base = $urandom();
            ts = ($urandom_range(0, 9) == 0) ? $urandom() : key_base + $urandom_range(0, 600000);
            if (roll < 45) begin
                send_request(rtlt_pkg::OP_REGISTER, ts, rand_time(), rand_time(), '0);
            end else if (roll < 92) begin
                send_request(rtlt_pkg::OP_LOOKUP, ts, rand63(), rand63(), rand_time());
            end else if (roll < 98) begin
                send_request(rtlt_pkg::OP_CLEANUP, ts, rand63(), rand63(), rand63());
                key_base = key_base + $urandom_range(0, 300000);
            end else begin
                send_request(rtlt_pkg::OP_CLEAR, $urandom(), rand63(), rand63(), rand63());
            end
            if (n % 400 == 399) write_offset({$urandom(), $urandom()} >>> $urandom_range(0, 63));
        end
    endtask

    initial begin
        errors = 0;
        tbl_count = 0;
        skew_ns = 0;
        hold_off = 1'b0;
        burst_left = 0;
        key_base = $urandom();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_offsets();
        test_fill_and_evict();
        test_backpressure();
        test_random(1500);
        wait_drained();
        if (errors == 0) begin
            $display("[rtp_timestamp_latency_table_core] OK");
        end else begin
            $display("[rtp_timestamp_latency_table_core] ERROR");
        end
        $finish;
    end
endmodule
